@@ src/oale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Command codes, stream field widths and the store write-enable group shared
// by the engine, its record store and its checker.
// ----------------------------------------------------------------------------
package oale_pkg;

  // Command codes carried in s_tuser.
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;
  localparam logic [2:0] CMD_FIND   = 3'd5;

  // Field widths fixed by the stream format.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 31;
  localparam int OCC_W   = 6;

  // Input tdata: at_end, position, key_in, count_in, padded to bytes.
  localparam int S_TDATA_W = 104;
  // Output tdata: ok, position_out, key_out, count_out, occupancy, is_empty.
  localparam int M_FIELDS_W = 1 + POS_W + KEY_W + COUNT_W + OCC_W + 1;
  localparam int M_TDATA_W  = 112;

  // Write enables for the two halves of a record.
  typedef struct packed {
    logic key_we;
    logic cnt_we;
  } store_we_t;

endpackage

@@ src/oale_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list record store
// Key and count memories with one write port and one registered read port,
// each with its own address; the count half can be written on its own.
// ----------------------------------------------------------------------------
module oale_store #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 64
) (
  input  logic                           clk,
  input  logic [$clog2(CAPACITY)-1:0]    waddr,
  input  oale_pkg::store_we_t            we,
  input  logic [KEY_BITS-1:0]            wkey,
  input  logic [oale_pkg::COUNT_W-1:0]   wcnt,
  input  logic [$clog2(CAPACITY)-1:0]    raddr,
  output logic [KEY_BITS-1:0]            rkey,
  output logic [oale_pkg::COUNT_W-1:0]   rcnt
);

  logic [KEY_BITS-1:0]          key_mem [CAPACITY];
  logic [oale_pkg::COUNT_W-1:0] cnt_mem [CAPACITY];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we.key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (we.cnt_we) begin
      cnt_mem[waddr] <= wcnt;
    end
    rkey <= key_mem[raddr];
    rcnt <= cnt_mem[raddr];
  end

endmodule

@@ src/ordered_array_list_engine.sv @@
`timescale 1ns / 1ps
// Clear, failed commands and unknown codes go straight to the result; get reads the
// record, then captures it; update writes the count; insert moves the records from
// the top down to the position one per cycle, then writes the new one; delete moves
// the records above the position down one per cycle; find compares one stored key
// per cycle until a match or the end of the list. One command at a time.
// Reset (synchronous, active high) empties the list and drops a pending result.
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity list of key and count records driven by one command per
// transfer: clear, insert, delete, get, update count and find by key.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] at_end, [5:1] position, [69:6] key_in, [100:70] count_in, rest zero
  input  logic [oale_pkg::S_TDATA_W-1:0]   s_tdata,
  // [2:0] command
  input  logic [oale_pkg::CMD_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] ok, [5:1] position_out, [69:6] key_out, [100:70] count_out,
  // [106:101] occupancy, [107] is_empty, rest zero
  output logic [oale_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = oale_pkg::POS_W;
  localparam int KW  = oale_pkg::KEY_W;
  localparam int NW  = oale_pkg::COUNT_W;
  localparam int OW  = oale_pkg::OCC_W;
  localparam int XW  = (CW > PW) ? CW : PW;
  localparam int PAD = oale_pkg::M_TDATA_W - oale_pkg::M_FIELDS_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_FLUSH,
    ST_PUT,
    ST_READ,
    ST_CAPTURE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t               state;
  logic [CW-1:0]        held;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        wr_addr;
  logic [CW-1:0]        dst_r;
  logic [CW-1:0]        cmp_idx;
  logic                 pend;
  logic [2:0]           cmd_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [NW-1:0]        cnt_r;
  logic                 res_ok;
  logic [PW-1:0]        res_pos;
  logic [KW-1:0]        res_key;
  logic [NW-1:0]        res_cnt;

  // Input field views.
  logic [2:0]           cmd_in;
  logic                 at_end_in;
  logic [PW-1:0]        pos_in;
  logic [KW-1:0]        key_in;
  logic [NW-1:0]        cnt_in;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        held_x;
  logic [XW-1:0]        dst_x;

  // Store port.
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  oale_pkg::store_we_t  we;
  logic [KEY_BITS-1:0]  wkey;
  logic [NW-1:0]        wcnt;
  logic [KEY_BITS-1:0]  rd_key;
  logic [NW-1:0]        rd_cnt;

  assign cmd_in    = s_tuser;
  assign at_end_in = s_tdata[0];
  assign pos_in    = s_tdata[5:1];
  assign key_in    = s_tdata[69:6];
  assign cnt_in    = s_tdata[100:70];

  assign pos_x  = XW'(pos_in);
  assign held_x = XW'(held);
  assign dst_x  = at_end_in ? held_x : pos_x;

  assign s_tready = (state == ST_IDLE);

  oale_store #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk   (clk),
    .waddr (waddr),
    .we    (we),
    .wkey  (wkey),
    .wcnt  (wcnt),
    .raddr (raddr),
    .rkey  (rd_key),
    .rcnt  (rd_cnt)
  );

  // Store addressing: reads follow the walk index, writes trail one record behind.
  always_comb begin
    raddr = (idx < CW'(CAPACITY)) ? idx[AW-1:0] : '0;
    waddr = wr_addr[AW-1:0];
    we    = '0;
    wkey  = rd_key;
    wcnt  = rd_cnt;
    unique case (state)
      ST_UP, ST_DOWN: begin
        we.key_we = pend;
        we.cnt_we = pend;
      end
      ST_FLUSH: begin
        we.key_we = 1'b1;
        we.cnt_we = 1'b1;
      end
      ST_PUT: begin
        waddr     = dst_r[AW-1:0];
        wkey      = key_r;
        wcnt      = cnt_r;
        we.key_we = (cmd_r == oale_pkg::CMD_INSERT);
        we.cnt_we = 1'b1;
      end
      default: begin
        we = '0;
      end
    endcase
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      held     <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The pending result leaves on a transfer unless a new one replaces it.
      if (m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r   <= cmd_in;
            key_r   <= key_in[KEY_BITS-1:0];
            cnt_r   <= cnt_in;
            res_ok  <= 1'b0;
            res_pos <= '0;
            res_key <= '0;
            res_cnt <= '0;
            pend    <= 1'b0;
            state   <= ST_DONE;
            unique case (cmd_in)
              oale_pkg::CMD_CLEAR: begin
                held   <= '0;
                res_ok <= 1'b1;
              end
              oale_pkg::CMD_INSERT: begin
                if ((held_x < XW'(CAPACITY)) && (dst_x <= held_x)) begin
                  res_ok  <= 1'b1;
                  res_pos <= dst_x[PW-1:0];
                  held    <= held + 1'b1;
                  dst_r   <= CW'(dst_x);
                  if (dst_x == held_x) begin
                    state <= ST_PUT;
                  end else begin
                    idx   <= held - 1'b1;
                    state <= ST_UP;
                  end
                end
              end
              oale_pkg::CMD_DELETE: begin
                if (pos_x < held_x) begin
                  res_ok  <= 1'b1;
                  res_pos <= pos_in;
                  held    <= held - 1'b1;
                  if (pos_x + 1'b1 != held_x) begin
                    idx   <= CW'(pos_x) + 1'b1;
                    state <= ST_DOWN;
                  end
                end
              end
              oale_pkg::CMD_GET: begin
                if (pos_x < held_x) begin
                  res_ok  <= 1'b1;
                  res_pos <= pos_in;
                  idx     <= CW'(pos_x);
                  state   <= ST_READ;
                end
              end
              oale_pkg::CMD_UPDATE: begin
                if (pos_x < held_x) begin
                  res_ok  <= 1'b1;
                  res_pos <= pos_in;
                  dst_r   <= CW'(pos_x);
                  state   <= ST_PUT;
                end
              end
              oale_pkg::CMD_FIND: begin
                if (held != '0) begin
                  idx   <= '0;
                  state <= ST_SCAN;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        // Move records up one place, walking down from the top to the target.
        ST_UP: begin
          wr_addr <= idx + 1'b1;
          pend    <= 1'b1;
          if (idx == dst_r) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx - 1'b1;
          end
        end

        // Move records down one place; held already counts the removal.
        ST_DOWN: begin
          wr_addr <= idx - 1'b1;
          pend    <= 1'b1;
          if (idx == held) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        // Write the last record read by the walk.
        ST_FLUSH: begin
          pend  <= 1'b0;
          state <= (cmd_r == oale_pkg::CMD_INSERT) ? ST_PUT : ST_DONE;
        end

        ST_PUT: begin
          state <= ST_DONE;
        end

        ST_READ: begin
          state <= ST_CAPTURE;
        end

        ST_CAPTURE: begin
          res_key <= KW'(rd_key);
          res_cnt <= rd_cnt;
          state   <= ST_DONE;
        end

        // Compare one stored key per cycle against the search key.
        ST_SCAN: begin
          if (pend && (rd_key == key_r)) begin
            res_ok  <= 1'b1;
            res_pos <= PW'(cmp_idx);
            res_key <= KW'(rd_key);
            res_cnt <= rd_cnt;
            pend    <= 1'b0;
            state   <= ST_DONE;
          end else if (idx == held) begin
            pend  <= 1'b0;
            state <= ST_DONE;
          end else begin
            pend    <= 1'b1;
            cmp_idx <= idx;
            idx     <= idx + 1'b1;
          end
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PAD{1'b0}}, (held == '0), OW'(held), res_cnt, res_key,
                         res_pos, res_ok};
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/oale_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module oale_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [oale_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready
);

  // A result stays put while the consumer stalls.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The engine is not ready in the cycle after it takes a command.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("engine ready right after a command transfer");

  // A failed command reports no position, key or count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[100:1] == '0)
    else $error("failed command carries payload");

  // The empty flag agrees with the occupancy.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[107] == (m_tdata[106:101] == '0))
    else $error("empty flag disagrees with occupancy");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind ordered_array_list_engine oale_chk u_oale_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
